[rtl/core/strongest_neighbor_aggregation_top_macros.svh]
// Assertion macros shared by the aggregation block.
`ifndef STRONGEST_NEIGHBOR_AGGREGATION_TOP_MACROS_SVH
`define STRONGEST_NEIGHBOR_AGGREGATION_TOP_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SNA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SNA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/sna_pkg.sv]
// ----------------------------------------------------------------------------
// sna_pkg
// Shared types and constants of the strongest-neighbour aggregation block.
// ----------------------------------------------------------------------------
`default_nettype none
package sna_pkg;
  localparam int NodeW  = 12;
  localparam int AggW   = 13;
  localparam int ValW   = 32;
  localparam int FracW  = 16;
  localparam int QuoW   = 48;
  localparam int DivCntW = 6;

  typedef logic [NodeW-1:0]        node_t;
  typedef logic signed [AggW-1:0]  agg_t;
  typedef logic signed [ValW-1:0]  val_t;

  localparam agg_t Unagg = '1;

  localparam logic [2:0] OutSkip  = 3'd0;
  localparam logic [2:0] OutJoin  = 3'd1;
  localparam logic [2:0] OutPair  = 3'd2;
  localparam logic [2:0] OutSelf  = 3'd3;
  localparam logic [2:0] OutOwn   = 3'd4;

  localparam logic [1:0] ModeStrong = 2'd0;
  localparam logic [1:0] ModeInPlace = 2'd1;
endpackage
`default_nettype wire

[rtl/core/strongest_neighbor_aggregation_top.sv]
// Operation: a load writes the node memories directly; a matrix entry occupies the block,
// which takes no new input, through accept, memory read, a divide of 48 quotient bits and the maximum update.
// A row end adds steps to read the chosen neighbour's aggregate and decide,
// and waits while an earlier result is still held in the output register.
// Synchronous active-low reset clears control and running maxima; the node
// memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// strongest_neighbor_aggregation_top
// Streaming strongest-neighbour aggregation over a memory-held node table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strongest_neighbor_aggregation_top_macros.svh"
module strongest_neighbor_aggregation_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [1:0]           cfg_mode,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_op,
  input  wire [11:0]          in_node_index,
  input  wire [11:0]          in_column,
  input  wire signed [31:0]   in_value,
  input  wire signed [12:0]   in_aggregate,
  input  wire                 in_entry_valid,
  input  wire                 in_row_last,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [11:0]         out_row,
  output logic [2:0]          out_outcome,
  output logic signed [12:0]  out_target
);
  import sna_pkg::*;

  // The state machine walks one transaction at a time through the memories.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_UPD   = 8'b0000_1000,
    S_END   = 8'b0001_0000,
    S_ENDRD = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] mode_r;

  // Node memories: aggregate id and diagonal, one write and one read port
  // each, plus a second read port on each for the column.
  agg_t agg_mem [2**NodeW];
  val_t diag_mem [2**NodeW];
  agg_t agg_row_q, agg_col_q;
  val_t diag_row_q, diag_col_q;

  logic  mem_we;
  node_t mem_wa;
  agg_t  mem_wagg;
  val_t  mem_wdiag;
  logic  diag_we;
  node_t rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      agg_mem[mem_wa] <= mem_wagg;
    end
    if (diag_we) begin
      diag_mem[mem_wa] <= mem_wdiag;
    end
    agg_row_q  <= agg_mem[rd_a];
    agg_col_q  <= agg_mem[rd_b];
    diag_row_q <= diag_mem[rd_a];
    diag_col_q <= diag_mem[rd_b];
  end

  // Captured transaction.
  node_t row_r, col_r;
  val_t  val_r;
  logic  ev_r, last_r;

  // Running maxima.
  val_t  bfw_r, bjw_r;
  agg_t  bfc_r, bjc_r;

  // Divider: numerator |v|<<16 over D, 48 quotient bits.
  logic [ValW-1:0]    dvs_r;
  logic [ValW:0]      rem_r;
  logic [QuoW-1:0]    num_r, quo_r;
  logic [DivCntW-1:0] cnt_r;
  logic               neg_r, zd_r, za_r, self_agg_r, col_free_r;

  logic [2:0] oc_r;
  agg_t       tgt_r;
  node_t      orow_r;
  logic       wr_tbl_r;
  logic       ov_r;

  // The result register parts the two sides, so a waiting result holds back only the
  // next row end, which stalls in S_ENDRD and blocks the input until the result is taken.
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  wire in_acc = in_valid && in_ready;

  // Magnitudes.
  logic [ValW-1:0] mr, mc, dmax, av;
  always_comb begin
    mr = diag_row_q[ValW-1] ? ValW'(-diag_row_q) : diag_row_q;
    mc = diag_col_q[ValW-1] ? ValW'(-diag_col_q) : diag_col_q;
    dmax = (mr > mc) ? mr : mc;
    av = val_r[ValW-1] ? ValW'(-val_r) : val_r;
  end

  logic [ValW:0] rem_sh, rem_sub;
  always_comb begin
    rem_sh  = {rem_r[ValW-1:0], num_r[QuoW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  // Saturated weight.
  val_t w_sat;
  always_comb begin
    if (za_r) begin
      w_sat = '0;
    end else if (zd_r) begin
      w_sat = neg_r ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else if (neg_r) begin
      w_sat = (quo_r > QuoW'({1'b1, {(ValW-1){1'b0}}})) ? {1'b1, {(ValW-1){1'b0}}}
                                                      : ValW'(-quo_r);
    end else begin
      w_sat = (quo_r > QuoW'({(ValW-1){1'b1}})) ? {1'b0, {(ValW-1){1'b1}}}
                                               : ValW'(quo_r);
    end
  end

  agg_t colx;
  assign colx = agg_t'({1'b0, col_r});
  wire bf_win = (w_sat > bfw_r) || (w_sat == bfw_r && colx > bfc_r);
  wire bj_win = (w_sat > bjw_r) || (w_sat == bjw_r && colx > bjc_r);
  wire row_free = (agg_row_q == Unagg);

  always_comb begin
    rd_a = in_node_index;
    rd_b = in_column;
    // The chosen neighbour's aggregate is read until the decision is taken.
    if (state_r == S_END || state_r == S_ENDRD) begin
      rd_b = bjc_r[NodeW-1:0];
    end
    mem_we = 1'b0;
    diag_we = 1'b0;
    mem_wa = in_node_index;
    mem_wagg = in_aggregate;
    mem_wdiag = in_value;
    if (in_acc && !in_op) begin
      mem_we = 1'b1;
      diag_we = 1'b1;
    end else if (state_r == S_FIN && wr_tbl_r) begin
      mem_we = 1'b1;
      mem_wa = row_r;
      mem_wagg = tgt_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && in_op) state_nxt = S_RD;
      S_RD:    state_nxt = S_DIV;
      S_DIV:   if (cnt_r == DivCntW'(QuoW)) state_nxt = S_UPD;
      S_UPD:   state_nxt = last_r ? S_END : S_IDLE;
      S_END:   state_nxt = S_ENDRD;
      S_ENDRD: if (!ov_r || out_ready) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= ModeStrong;
      ov_r    <= 1'b0;
      bfw_r <= '0; bfc_r <= Unagg; bjw_r <= '0; bjc_r <= Unagg;
      wr_tbl_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_mode;
      end
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_UPD: begin
          if (self_agg_r && ev_r && col_r != row_r) begin
            if (col_free_r) begin
              if (mode_r == ModeStrong && bf_win) begin
                bfw_r <= w_sat; bfc_r <= colx;
              end
            end else if (bj_win) begin
              bjw_r <= w_sat; bjc_r <= colx;
            end
          end
        end
        S_FIN: begin
          ov_r <= 1'b1;
          wr_tbl_r <= 1'b0;
          bfw_r <= '0; bfc_r <= Unagg; bjw_r <= '0; bjc_r <= Unagg;
        end
        S_OUT: begin
          if (!self_agg_r) begin
            wr_tbl_r <= 1'b0;
          end else if (mode_r == ModeStrong) begin
            wr_tbl_r <= (bfc_r == Unagg && bjc_r != Unagg);
          end else begin
            wr_tbl_r <= (mode_r == ModeInPlace);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc && in_op) begin
      row_r <= in_node_index; col_r <= in_column; val_r <= in_value;
      ev_r <= in_entry_valid; last_r <= in_row_last;
    end
    case (state_r)
      S_RD: begin
        dvs_r <= dmax;
        num_r <= {av, {FracW{1'b0}}};
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
        neg_r <= val_r[ValW-1];
        za_r  <= (av == '0);
        zd_r  <= (dmax == '0);
        self_agg_r <= row_free;
        col_free_r <= (agg_col_q == Unagg);
      end
      S_DIV: begin
        if (cnt_r != DivCntW'(QuoW)) begin
          cnt_r <= cnt_r + 1'b1;
          num_r <= {num_r[QuoW-2:0], 1'b0};
          if (!rem_sub[ValW]) begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[QuoW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QuoW-2:0], 1'b0};
          end
        end
      end
      S_UPD: begin
        // no datapath register changes here; the running maxima update in the control block
      end
      S_OUT: begin
        orow_r <= row_r;
        if (!self_agg_r) begin
          oc_r <= OutSkip; tgt_r <= Unagg;
        end else if (mode_r == ModeStrong) begin
          if (bfc_r == Unagg && bjc_r != Unagg) begin
            oc_r <= OutJoin; tgt_r <= agg_col_q;
          end else if (bfc_r != Unagg) begin
            oc_r <= OutPair; tgt_r <= bfc_r;
          end else begin
            oc_r <= OutSelf; tgt_r <= agg_t'({1'b0, row_r});
          end
        end else if (bjc_r != Unagg) begin
          oc_r <= OutJoin; tgt_r <= agg_col_q;
        end else begin
          oc_r <= OutOwn; tgt_r <= agg_t'({1'b0, row_r});
        end
      end
      default: ;
    endcase
  end

  assign out_row     = orow_r;
  assign out_outcome = oc_r;
  assign out_target  = tgt_r;

  `SNA_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready, "input taken while busy")
  `SNA_ASSERT_NEXT(a_fin_out, state_r == S_FIN, out_valid, "row end gave no result")
  `SNA_ASSERT_IMP(a_oc_range, out_valid, out_outcome <= OutOwn, "outcome out of range")
endmodule
`default_nettype wire
